FILE: rtl/core/vnt_pkg.sv
// Shared types and constants for the value noise turbulence block.
// Holds the permutation ROM, register indexes, sequencer states and the table write port.
// No dependencies.
package vnt_pkg;

  localparam logic [31:0] LCG_MULT = 32'h015a4e35;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OCTAVES   = 2'd0,
    REG_FOUR_DIMS = 2'd1,
    REG_SEED      = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_SQ,
    ST_SM_POLY,
    ST_HASH_Z,
    ST_HASH_Y,
    ST_READ,
    ST_DATA,
    ST_REDUCE,
    ST_LERP_MUL,
    ST_LERP_ADD,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } core_state_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } ram_wr_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd225,8'd155,8'd210,8'd108,8'd175,8'd199,8'd221,8'd144,
    8'd203,8'd116,8'd70,8'd213,8'd69,8'd158,8'd33,8'd252,
    8'd5,8'd82,8'd173,8'd133,8'd222,8'd139,8'd174,8'd27,
    8'd9,8'd71,8'd90,8'd246,8'd75,8'd130,8'd91,8'd191,
    8'd169,8'd138,8'd2,8'd151,8'd194,8'd235,8'd81,8'd7,
    8'd25,8'd113,8'd228,8'd159,8'd205,8'd253,8'd134,8'd142,
    8'd248,8'd65,8'd224,8'd217,8'd22,8'd121,8'd229,8'd63,
    8'd89,8'd103,8'd96,8'd104,8'd156,8'd17,8'd201,8'd129,
    8'd36,8'd8,8'd165,8'd110,8'd237,8'd117,8'd231,8'd56,
    8'd132,8'd211,8'd152,8'd20,8'd181,8'd111,8'd239,8'd218,
    8'd170,8'd163,8'd51,8'd172,8'd157,8'd47,8'd80,8'd212,
    8'd176,8'd250,8'd87,8'd49,8'd99,8'd242,8'd136,8'd189,
    8'd162,8'd115,8'd44,8'd43,8'd124,8'd94,8'd150,8'd16,
    8'd141,8'd247,8'd32,8'd10,8'd198,8'd223,8'd255,8'd72,
    8'd53,8'd131,8'd84,8'd57,8'd220,8'd197,8'd58,8'd50,
    8'd208,8'd11,8'd241,8'd28,8'd3,8'd192,8'd62,8'd202,
    8'd18,8'd215,8'd153,8'd24,8'd76,8'd41,8'd15,8'd179,
    8'd39,8'd46,8'd55,8'd6,8'd128,8'd167,8'd23,8'd188,
    8'd106,8'd34,8'd187,8'd140,8'd164,8'd73,8'd112,8'd182,
    8'd244,8'd195,8'd227,8'd13,8'd35,8'd77,8'd196,8'd185,
    8'd26,8'd200,8'd226,8'd119,8'd31,8'd123,8'd168,8'd125,
    8'd249,8'd68,8'd183,8'd230,8'd177,8'd135,8'd160,8'd180,
    8'd12,8'd1,8'd243,8'd148,8'd102,8'd166,8'd38,8'd238,
    8'd251,8'd37,8'd240,8'd126,8'd64,8'd74,8'd161,8'd40,
    8'd184,8'd149,8'd171,8'd178,8'd101,8'd66,8'd29,8'd59,
    8'd146,8'd61,8'd254,8'd107,8'd42,8'd86,8'd154,8'd4,
    8'd236,8'd232,8'd120,8'd21,8'd233,8'd209,8'd45,8'd98,
    8'd193,8'd114,8'd78,8'd19,8'd206,8'd14,8'd118,8'd127,
    8'd48,8'd79,8'd147,8'd85,8'd30,8'd207,8'd219,8'd54,
    8'd88,8'd234,8'd190,8'd122,8'd95,8'd67,8'd143,8'd109,
    8'd137,8'd214,8'd145,8'd93,8'd92,8'd100,8'd245,8'd0,
    8'd216,8'd186,8'd60,8'd83,8'd105,8'd97,8'd204,8'd52
  };

endpackage

FILE: rtl/core/vnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the value table; no dependencies.
module vnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/vnt_fill.sv
// Value table fill sequencer: runs the LCG 256 steps from the seed.
// Depends on vnt_pkg (ram_wr_t, LCG_MULT).
module vnt_fill import vnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] seed,
  output ram_wr_t     wr,
  output logic        busy
);

  logic [31:0] gen_state;
  logic [31:0] gen_next;
  logic [7:0]  cnt;

  assign gen_next = gen_state * LCG_MULT + 32'd1;

  always_comb begin
    wr.en   = busy;
    wr.addr = cnt;
    wr.data = gen_next[23:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      cnt       <= '0;
      gen_state <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      cnt       <= '0;
      gen_state <= seed;
    end else if (busy) begin
      gen_state <= gen_next;
      cnt       <= cnt + 8'd1;
      if (cnt == 8'd255) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/vnt_core.sv
// Noise sequencer: smoothstep, corner hashing, lerp tree, octave sum and final divide;
// smoothstep and lerp share one multiplier. Depends on vnt_pkg.
module vnt_core import vnt_pkg::*; #(
  parameter int MAX_OCTAVES     = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_w,
  input  logic        four,
  input  logic [4:0]  n_oct,
  output logic [7:0]  rd_addr,
  input  logic [7:0]  rd_data,
  output logic        idle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] turbulence
);

  localparam int F     = COORD_FRAC_BITS;
  localparam int ACC_W = 25 + MAX_OCTAVES;
  localparam int SHR   = (F >= 16) ? F - 16 : 0;
  localparam int SHL   = (F < 16) ? 16 - F : 0;
  localparam logic [31:0] FMASK = 32'((64'd1 << F) - 64'd1);
  localparam logic [24:0] SAT_LIMIT = 25'd16711680;

  function automatic logic [15:0] frac16(input logic [31:0] c);
    logic [31:0] m;
    m = (c & FMASK) >> SHR;
    return 16'(m << SHL);
  endfunction

  core_state_t state, state_next;

  logic [31:0] cx, cy, cz, cw;
  logic        four_r;
  logic [4:0]  n_r, oct_i;
  logic [1:0]  sd;
  logic [16:0] s_r [4];
  logic [3:0]  k;
  logic [7:0]  hz, hy;
  logic [23:0] cur;
  logic [23:0] pend [4];
  logic [2:0]  lvl;
  logic        sub_r;
  logic [40:0] prod;
  logic [ACC_W-1:0] acc;
  logic [23:0] num;
  logic [16:0] quo;
  logic        div_cnt;
  logic        sat_r;

  logic [2:0]  ndim;
  logic [4:0]  n_sat;
  logic [31:0] csel;
  logic [15:0] fsel;
  logic [16:0] mul_a;
  logic [23:0] mul_b;
  logic [40:0] mul_out;
  logic [7:0]  ix, iy, iz, iw;
  logic [7:0]  hz_calc, hy_calc;
  logic [23:0] lerp_a, lerp_diff;
  logic        lerp_sub;
  logic [16:0] q_est;
  logic [24:0] div_r;
  logic [1:0]  q_fix;

  assign ndim  = four_r ? 3'd4 : 3'd3;
  assign n_sat = (n_oct > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : n_oct;
  assign ix    = cx[F+7:F];
  assign iy    = cy[F+7:F];
  assign iz    = cz[F+7:F];
  assign iw    = cw[F+7:F];
  assign idle  = (state == ST_IDLE);

  always_comb begin
    case (sd)
      2'd0:    csel = cx;
      2'd1:    csel = cy;
      2'd2:    csel = cz;
      default: csel = cw;
    endcase
  end
  assign fsel = frac16(csel);

  assign hz_calc = four_r ? (iz + 8'(k[2]) + PERM_ROM[iw + 8'(k[3])]) : (iz + 8'(k[2]));
  assign hy_calc = iy + 8'(k[1]) + PERM_ROM[hz];

  assign lerp_a    = pend[lvl[1:0]];
  assign lerp_sub  = lerp_a > cur;
  assign lerp_diff = lerp_sub ? (lerp_a - cur) : (cur - lerp_a);

  // x/255 from below by x/256 + x/65536; the remainder then stays at most 3*255
  assign q_est = 17'(num[23:8]) + 17'(num[23:16]);
  assign div_r = {1'b0, num} - ({quo, 8'd0} - 25'(quo));
  assign q_fix = (div_r >= 25'd510) ? 2'd2 : ((div_r >= 25'd255) ? 2'd1 : 2'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = (n_sat == 5'd0) ? ST_DIV_INIT : ST_SM_SQ;
      ST_SM_SQ:    state_next = ST_SM_POLY;
      ST_SM_POLY:  state_next = ({1'b0, sd} == ndim - 3'd1) ? ST_HASH_Z : ST_SM_SQ;
      ST_HASH_Z:   state_next = ST_HASH_Y;
      ST_HASH_Y:   state_next = ST_READ;
      ST_READ:     state_next = ST_DATA;
      ST_DATA:     state_next = ST_REDUCE;
      ST_REDUCE: begin
        if (lvl == ndim) state_next = ST_ACCUM;
        else if (k[lvl[1:0]]) state_next = ST_LERP_MUL;
        else state_next = ST_HASH_Z;
      end
      ST_LERP_MUL: state_next = ST_LERP_ADD;
      ST_LERP_ADD: state_next = ST_REDUCE;
      ST_ACCUM:    state_next = (oct_i + 5'd1 == n_r) ? ST_DIV_INIT : ST_SM_SQ;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (div_cnt) state_next = ST_DONE;
      ST_DONE:     if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // shared multiplier operands and table address
  always_comb begin
    mul_a   = {1'b0, fsel};
    mul_b   = {8'd0, fsel};
    rd_addr = ix + 8'(k[0]) + PERM_ROM[hy];
    unique case (state)
      ST_SM_POLY: begin
        mul_a = prod[32:16];
        mul_b = 24'(18'd196608 - {1'b0, fsel, 1'b0});
      end
      ST_LERP_MUL: begin
        mul_a = s_r[lvl[1:0]];
        mul_b = lerp_diff;
      end
      default: begin
        mul_a = {1'b0, fsel};
        mul_b = {8'd0, fsel};
      end
    endcase
  end
  assign mul_out = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cx     <= in_x;
        cy     <= in_y;
        cz     <= in_z;
        cw     <= in_w;
        four_r <= four;
        n_r    <= n_sat;
        oct_i  <= '0;
        sd     <= '0;
        acc    <= '0;
      end
      ST_SM_SQ: prod <= mul_out;
      ST_SM_POLY: begin
        s_r[sd] <= mul_out[32:16];
        sd      <= sd + 2'd1;
        k       <= '0;
      end
      ST_HASH_Z: hz <= hz_calc;
      ST_HASH_Y: hy <= hy_calc;
      ST_DATA: begin
        cur <= {rd_data, 16'd0};
        lvl <= '0;
      end
      ST_REDUCE: begin
        // park the value until its sibling arrives
        if (lvl != ndim && !k[lvl[1:0]]) begin
          pend[lvl[1:0]] <= cur;
          k              <= k + 4'd1;
        end
      end
      ST_LERP_MUL: begin
        prod  <= mul_out;
        sub_r <= lerp_sub;
      end
      ST_LERP_ADD: begin
        cur <= sub_r ? (lerp_a - prod[39:16]) : (lerp_a + prod[39:16]);
        lvl <= lvl + 3'd1;
      end
      ST_ACCUM: begin
        acc   <= acc + (ACC_W'(cur) << (5'(MAX_OCTAVES - 1) - oct_i));
        cx    <= cx << 1;
        cy    <= cy << 1;
        cz    <= cz << 1;
        cw    <= cw << 1;
        oct_i <= oct_i + 5'd1;
        sd    <= '0;
      end
      ST_DIV_INIT: begin
        sat_r   <= (acc[ACC_W-1:MAX_OCTAVES] >= SAT_LIMIT);
        num     <= acc[MAX_OCTAVES+23:MAX_OCTAVES];
        div_cnt <= 1'b0;
      end
      ST_DIV: begin
        // divide by 255: take the shift estimate, then add the remainder correction
        if (!div_cnt) begin
          quo <= q_est;
        end else begin
          quo <= quo + 17'(q_fix);
        end
        div_cnt <= 1'b1;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          turbulence <= sat_r ? 17'd65536 : quo;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/value_noise_turbulence.sv
// Value noise turbulence. One point at a time; in_stall is high while a point is in work.
// Processing time grows with the octave count (saturated to MAX_OCTAVES) and is longer in 4D;
// it is set by the single shared multiplier and one table read port.
// The next point is taken once the current result is in the output register.
// Reset (synchronous, active high) restores defaults and refills the value table from seed 0;
// every seed write refills it the same way. No point is taken meanwhile.
module value_noise_turbulence import vnt_pkg::*; #(
  parameter int MAX_OCTAVES     = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  input  logic signed [31:0]    coord_z,
  input  logic signed [31:0]    coord_w,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [16:0]           turbulence
);

  logic [4:0] octave_count;
  logic       use_four_dims;
  logic       seed_write;
  ram_wr_t    tbl_wr;
  logic       fill_busy;
  logic [7:0] rd_addr, rd_data;
  logic       core_idle;
  logic       start;

  always_comb begin
    seed_write = 1'b0;
    unique case (cfg_index)
      REG_SEED: seed_write = cfg_write;
      default:  seed_write = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count  <= 5'd4;
      use_four_dims <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OCTAVES:   octave_count  <= cfg_data[4:0];
        REG_FOUR_DIMS: use_four_dims <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  assign in_stall = !core_idle || fill_busy;
  assign start    = in_valid && !in_stall;

  vnt_fill u_fill (
    .clk   (clk),
    .rst   (rst),
    .start (seed_write),
    .seed  (cfg_data),
    .wr    (tbl_wr),
    .busy  (fill_busy)
  );

  vnt_ram #(.WIDTH(8), .DEPTH(256)) u_table (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  vnt_core #(
    .MAX_OCTAVES     (MAX_OCTAVES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .in_x       (coord_x),
    .in_y       (coord_y),
    .in_z       (coord_z),
    .in_w       (coord_w),
    .four       (use_four_dims),
    .n_oct      (octave_count),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .idle       (core_idle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .turbulence (turbulence)
  );

  a_no_take_during_fill: assert property (@(posedge clk) disable iff (rst)
    start |-> !fill_busy)
    else $error("point taken while value table fills");

  a_seed_starts_fill: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == REG_SEED) |=> fill_busy)
    else $error("seed write did not start a table fill");

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turbulence <= 17'd65536)
    else $error("turbulence above one");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("ready again right after a transfer");

endmodule

FILE: verif/tb_value_noise_turbulence.sv
// Self-checking testbench for value_noise_turbulence: random and directed points with a
// bit-exact fractal value noise predictor and an in-order result check.
// Depends on vnt_pkg and the value_noise_turbulence RTL.
module tb_value_noise_turbulence;
  import vnt_pkg::*;

  localparam int OCT_LIMIT = 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [31:0]    coord_x = '0;
  logic signed [31:0]    coord_y = '0;
  logic signed [31:0]    coord_z = '0;
  logic signed [31:0]    coord_w = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [16:0]           turbulence;

  value_noise_turbulence u_top (.*);

  always #5 clk = ~clk;

  // predictor copy of the block's registers and value table
  bit [4:0]    octaves_reg;
  bit          four_dims_reg;
  bit [7:0]    lattice_bytes [256];
  bit [16:0]   pending_turb [$];
  int          errors;
  bit          send_gaps;
  bit          recv_stalls;
  int          stall_left = 0;

  task automatic report(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic void refill_bytes(bit [31:0] seed);
    bit [31:0] lcg;
    lcg = seed;
    for (int k = 0; k < 256; k++) begin
      lcg = lcg * LCG_MULT + 32'd1;
      lattice_bytes[k] = lcg[23:16];
    end
  endfunction

  function automatic longint unsigned smoothstep(bit [15:0] f);
    longint unsigned f2, t;
    f2 = (longint'(f) * longint'(f)) >> 16;
    t = 64'd196608 - 2 * longint'(f);
    return (f2 * t) >> 16;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned s);
    if (b >= a) return a + ((s * (b - a)) >> 16);
    return a - ((s * (a - b)) >> 16);
  endfunction

  function automatic longint unsigned corner_val(bit [7:0] ix, bit [7:0] iy, bit [7:0] iz,
                                                 bit [7:0] iw, bit four);
    bit [7:0] h;
    h = four ? iz + PERM_ROM[iw] : iz;
    h = iy + PERM_ROM[h];
    h = ix + PERM_ROM[h];
    return longint'(lattice_bytes[h]) << 16;
  endfunction

  function automatic longint unsigned cell_blend(bit [7:0] ix, bit [7:0] iy, bit [7:0] iz,
      bit [7:0] iw, bit four, longint unsigned sx, longint unsigned sy, longint unsigned sz);
    longint unsigned l1, l2, l3, l4;
    l1 = blend(corner_val(ix, iy, iz, iw, four), corner_val(ix+8'd1, iy, iz, iw, four), sx);
    l2 = blend(corner_val(ix, iy+8'd1, iz, iw, four),
               corner_val(ix+8'd1, iy+8'd1, iz, iw, four), sx);
    l3 = blend(corner_val(ix, iy, iz+8'd1, iw, four),
               corner_val(ix+8'd1, iy, iz+8'd1, iw, four), sx);
    l4 = blend(corner_val(ix, iy+8'd1, iz+8'd1, iw, four),
               corner_val(ix+8'd1, iy+8'd1, iz+8'd1, iw, four), sx);
    return blend(blend(l1, l2, sy), blend(l3, l4, sy), sz);
  endfunction

  function automatic bit [16:0] turbulence_of(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                                              bit [31:0] w);
    longint unsigned acc, lo, res;
    int n;
    acc = 0;
    n = (octaves_reg > OCT_LIMIT) ? OCT_LIMIT : octaves_reg;
    for (int i = 0; i < n; i++) begin
      lo = cell_blend(x[23:16], y[23:16], z[23:16], w[23:16], four_dims_reg,
                      smoothstep(x[15:0]), smoothstep(y[15:0]), smoothstep(z[15:0]));
      if (four_dims_reg)
        lo = blend(lo, cell_blend(x[23:16], y[23:16], z[23:16], w[23:16] + 8'd1, 1'b1,
                   smoothstep(x[15:0]), smoothstep(y[15:0]), smoothstep(z[15:0])),
                   smoothstep(w[15:0]));
      acc += lo << (OCT_LIMIT - 1 - i);
      x = x << 1;
      y = y << 1;
      z = z << 1;
      w = w << 1;
    end
    res = acc / (64'd255 << OCT_LIMIT);
    if (res > 65536) res = 65536;
    return res[16:0];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls, changed at the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (recv_stalls && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_turb.size() == 0) report("unexpected result", -1, turbulence);
      else begin
        bit [16:0] exp_turb;
        exp_turb = pending_turb.pop_front();
        if (turbulence !== exp_turb) report("turbulence", exp_turb, turbulence);
      end
    end
  end

  task automatic send_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] w);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    coord_w <= w;
    do @(posedge clk); while (in_stall);
    pending_turb.push_back(turbulence_of(x, y, z, w));
    @(negedge clk);
  endtask

  // wait for every result, then let the block settle before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_turb.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_OCTAVES:   octaves_reg = value[4:0];
      REG_FOUR_DIMS: four_dims_reg = value[0];
      REG_SEED:      refill_bytes(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    for (int k = 0; k < count; k++)
      send_point($urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_defaults();
    send_point(0, 0, 0, 0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'hffffffff, 32'h0000ffff, 32'hfffe8000, 32'h00018000);
    send_point(32'h00010000, 32'hffff0000, 32'h00ff0000, 32'h0000ffff);
    drain();
  endtask

  task automatic test_octave_counts();
    bit [31:0] counts [5] = '{0, 1, 16, 17, 31};
    foreach (counts[j]) begin
      write_reg(REG_OCTAVES, counts[j]);
      send_point(32'h00123456, 32'hfff0abcd, 32'h7fff8001, 32'h80007fff);
      send_point($urandom, $urandom, $urandom, $urandom);
      drain();
    end
  endtask

  task automatic test_dims_and_seeds();
    write_reg(REG_OCTAVES, 3);
    write_reg(REG_FOUR_DIMS, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h12345678);
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h87654321);
    drain();
    write_reg(REG_SEED, 32'hffffffff);
    send_point(32'h00008000, 32'hffff8000, 32'h00000001, 0);
    drain();
    write_reg(REG_FOUR_DIMS, 1);
    write_reg(REG_SEED, 32'h0);
    send_point(32'h00008000, 32'hffff8000, 32'h00000001, 32'hfffffffe);
    drain();
    // unused register slot: nothing changes
    cfg_write <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= $urandom;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    send_point(32'h00008000, 32'hffff8000, 32'h00000001, 32'hfffffffe);
    drain();
  endtask

  task automatic test_random();
    for (int p = 0; p < 16; p++) begin
      write_reg(REG_OCTAVES, ($urandom_range(0, 9) == 0) ? $urandom_range(16, 31)
                                                          : $urandom_range(0, 5));
      write_reg(REG_FOUR_DIMS, $urandom_range(0, 1));
      write_reg(REG_SEED, $urandom);
      send_gaps = (p % 4) != 1;
      recv_stalls = (p % 4) != 2;
      send_random(100);
      drain();
    end
  endtask

  initial begin
    octaves_reg = 5'd4;
    four_dims_reg = 1'b1;
    refill_bytes(32'd0);
    errors = 0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_defaults();
    test_octave_counts();
    test_dims_and_seeds();
    test_random();
    drain();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #400000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/vnt_pkg.sv
rtl/core/vnt_ram.sv
rtl/core/vnt_fill.sv
rtl/core/vnt_core.sv
rtl/core/value_noise_turbulence.sv
verif/tb_value_noise_turbulence.sv
